// File: rtl/srcc_pkg.sv
// Package for the sensor reply CRC check and conversion block.
// Holds the shared item and result types, the CRC-8 constants and the byte update.
// No dependencies.
package srcc_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  // Byte positions within one reply frame.
  localparam logic [2:0] PosTempMsb = 3'd0;
  localparam logic [2:0] PosTempLsb = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumMsb  = 3'd3;
  localparam logic [2:0] PosHumLsb  = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusMismatch = 1'b1;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] reply_byte;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic signed [8:0] temperature_c;
    logic        [6:0] humidity_pct;
  } result_t;

  // CRC-8, MSB first, no reflection, no final xor.
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/srcc_frame_core.sv
// Frame tracker for the sensor reply block: byte position, CRC check and conversion.
// Depends on srcc_pkg for the item and result types and the CRC update.
module srcc_frame_core
  import srcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  in_item_t item_i,
  output logic     has_result_o,
  output result_t  result_o
);

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic [15:0] word_q, word_d;
  logic [15:0] temp_raw_q, temp_raw_d;
  logic        temp_ok_q, temp_ok_d;

  logic [23:0] temp_prod;
  logic [22:0] hum_prod;
  logic [16:0] temp_sum, hum_sum;
  logic [7:0]  temp_deg;
  logic [6:0]  hum_pct;
  logic        frame_ok;

  // A start flag forces position zero; an impossible position also restarts.
  always_comb begin
    if (item_i.frame_start || pos_q > PosHumCrc) begin
      pos = PosTempMsb;
    end else begin
      pos = pos_q;
    end
  end

  assign has_result_o = (pos == PosHumCrc);

  // x / 65535 with x = a*2^16 + b equals a plus one when a + b reaches 65535.
  assign temp_prod = temp_raw_q * 24'd175;
  assign hum_prod  = word_q * 23'd100;
  assign temp_sum  = 17'(temp_prod[23:16]) + 17'(temp_prod[15:0]);
  assign hum_sum   = 17'(hum_prod[22:16]) + 17'(hum_prod[15:0]);
  assign temp_deg  = temp_prod[23:16] + 8'(temp_sum >= 17'd65535);
  assign hum_pct   = hum_prod[22:16] + 7'(hum_sum >= 17'd65535);

  assign frame_ok = temp_ok_q && (crc_q == item_i.reply_byte);

  always_comb begin
    result_o.status        = frame_ok ? StatusOk : StatusMismatch;
    result_o.temperature_c = frame_ok ? $signed({1'b0, temp_deg}) - 9'sd45 : 9'sd0;
    result_o.humidity_pct  = frame_ok ? hum_pct : 7'd0;
  end

  always_comb begin
    crc_d       = crc_q;
    high_byte_d = high_byte_q;
    word_d      = word_q;
    temp_raw_d  = temp_raw_q;
    temp_ok_d   = temp_ok_q;
    pos_d       = (pos >= PosHumCrc) ? PosTempMsb : pos + 3'd1;
    case (pos)
      PosTempMsb, PosHumMsb: begin
        crc_d       = crc8_byte(CrcInit, item_i.reply_byte);
        high_byte_d = item_i.reply_byte;
      end
      PosTempLsb, PosHumLsb: begin
        crc_d  = crc8_byte(crc_q, item_i.reply_byte);
        word_d = {high_byte_q, item_i.reply_byte};
      end
      PosTempCrc: begin
        temp_ok_d  = (crc_q == item_i.reply_byte);
        temp_raw_d = word_q;
        crc_d      = CrcInit;
      end
      default: begin
        crc_d = CrcInit;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= PosTempMsb;
      crc_q     <= CrcInit;
      temp_ok_q <= 1'b0;
    end else if (advance_i) begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      temp_ok_q <= temp_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      high_byte_q <= high_byte_d;
      word_q      <= word_d;
      temp_raw_q  <= temp_raw_d;
    end
  end

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosHumCrc)
    else $error("byte position left the frame");

  a_start_resync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.frame_start |=> pos_q == PosTempLsb)
    else $error("frame start did not resynchronize the position");

  a_wrap_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && has_result_o |=> pos_q == PosTempMsb && crc_q == CrcInit)
    else $error("frame did not restart after its result");

endmodule

// File: rtl/sensor_reply_crc_convert.sv
// Top level of the sensor reply CRC check and conversion block.
// Depends on srcc_pkg and srcc_frame_core.
//
//  channel  | direction | tdata (low bit up)                 | tuser
//  s_axis   | in        | reply_byte[7:0]                    | frame_start
//  m_axis   | out       | temperature_c[8:0], humidity_pct[6:0] | status
//
// One byte is taken per cycle unless a held result stalls the input register.
// The input register feeds the frame tracker, whose result lands in the output register.
// Bytes that produce no result move on even while the output is stalled.
// A held result stalls only the sixth byte of the next frame.
// Reset returns the byte position to the start of a frame and empties both registers.
module sensor_reply_crc_convert
  import srcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // reply_byte[7:0]
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // temperature_c[8:0], humidity_pct[6:0]
  output logic        m_axis_tuser    // status
);

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     out_valid_q, out_valid_d;
  result_t  out_q;
  logic     has_result;
  result_t  result;
  logic     advance;
  logic     out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!has_result || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  srcc_frame_core u_frame_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .item_i       (in_item_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.reply_byte  <= s_axis_tdata;
      in_item_q.frame_start <= s_axis_tuser;
    end
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.humidity_pct, out_q.temperature_c};
  assign m_axis_tuser  = out_q.status;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result |-> out_free)
    else $error("result register overwritten while held");

  a_stalled_byte_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("stalled input byte was lost");

  a_mismatch_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result && result.status == StatusMismatch
      |=> out_q.temperature_c == 9'sd0 && out_q.humidity_pct == 7'd0)
    else $error("mismatch result carries nonzero values");

endmodule
